/* design/tcpp_pkg.sv */
package tcpp_pkg;

  // parse phases
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_KIND    = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  // record types
  localparam logic [2:0] REC_HEADER  = 3'd0;
  localparam logic [2:0] REC_OPTION  = 3'd1;
  localparam logic [2:0] REC_OPTDATA = 3'd2;
  localparam logic [2:0] REC_PAYLOAD = 3'd3;
  localparam logic [2:0] REC_STATUS  = 3'd4;

  // status codes
  localparam logic [7:0] ST_OK      = 8'd0;
  localparam logic [7:0] ST_TRUNC   = 8'd1;
  localparam logic [7:0] ST_OFFSET  = 8'd2;
  localparam logic [7:0] ST_LENGTH  = 8'd3;
  localparam logic [7:0] ST_OVERRUN = 8'd4;

  localparam logic [5:0] FIXED_HEADER    = 6'd20;
  localparam logic [3:0] MIN_OFFSET      = 4'd5;
  localparam logic [7:0] SINGLE_BYTE_MAX = 8'd1;
  localparam logic [7:0] KIND_LEN_BYTES  = 8'd2;
  localparam int         HDR_BITS        = 160;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_segment;
  } seg_beat_t;

  typedef struct packed {
    logic [2:0]  record_type;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [15:0] offset_and_flags;
    logic [15:0] window_size;
    logic [15:0] checksum_word;
    logic [15:0] urgent_pointer;
    logic [7:0]  item_value;
    logic [7:0]  option_data_length;
    logic        last_of_run;
  } rec_beat_t;

  function automatic rec_beat_t make_rec(logic [2:0] kind, logic [7:0] value,
                                         logic [7:0] dlen);
    rec_beat_t r;
    r = '0;
    r.record_type        = kind;
    r.item_value         = value;
    r.option_data_length = dlen;
    return r;
  endfunction

endpackage

/* design/tcpp_seg_if.sv */
interface tcpp_seg_if;
  logic                 valid;
  logic                 ready;
  tcpp_pkg::seg_beat_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/tcpp_rec_if.sv */
interface tcpp_rec_if;
  logic                 valid;
  logic                 ready;
  tcpp_pkg::rec_beat_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/tcp_header_option_parser_unit.sv */
// TCP header and option parser. Takes one segment byte per beat (end_of_segment
// on the final byte) and emits header, option, option data, payload and status
// records. Each byte is parsed in the cycle it is accepted and yields zero, one
// or two records, which go into a 4-entry record queue; a byte is accepted
// whenever the queue has room for two records, so with the record side ready
// the unit takes one byte every cycle. A byte that yields two records (e.g.
// the final byte with its status) writes both into the queue at once. After a
// parse error the status record is emitted and the remaining bytes of the
// segment are dropped silently.
module tcp_header_option_parser_unit (
  input  logic              clk,
  input  logic              rst,
  tcpp_seg_if.sink          segment,
  tcpp_rec_if.source        result
);
  import tcpp_pkg::*;

  logic [2:0]          phase, phase_next;
  logic [5:0]          pos, pos_next;
  logic [HDR_BITS-1:0] hdr_shift, hdr_shift_next;
  logic [5:0]          hdr_end, hdr_end_next;
  logic [7:0]          opt_left, opt_left_next;
  logic [7:0]          pend_kind, pend_kind_next;
  logic                drop, drop_next;

  rec_beat_t           rq [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [RQ_CNT_W-1:0] rq_cnt;

  logic       accept, pop;
  logic [7:0] b;
  logic       last;
  rec_beat_t  rec0, rec1;
  logic [1:0] nrec;
  logic       err;
  logic [7:0] err_code;
  logic       need_more;
  logic [5:0] pos_inc;
  logic [7:0] dlen;
  logic [8:0] opt_end;
  logic [3:0] doff;
  logic       go_reset;

  assign b      = segment.payload.data_byte;
  assign last   = segment.payload.end_of_segment;
  assign accept = segment.valid && segment.ready;
  assign pop    = result.valid && result.ready;

  assign segment.ready  = rq_cnt <= RQ_CNT_W'(RQ_DEPTH - 2);
  assign result.valid   = rq_cnt != '0;
  assign result.payload = rq[rd_ptr];

  assign pos_inc = pos + 6'd1;
  assign dlen    = b - KIND_LEN_BYTES;
  assign opt_end = {3'b000, pos_inc} + {1'b0, dlen};
  assign doff    = hdr_shift_next[63:60];

  always_comb begin
    phase_next     = phase;
    pos_next       = pos;
    hdr_shift_next = {hdr_shift[HDR_BITS-9:0], b};
    hdr_end_next   = hdr_end;
    opt_left_next  = opt_left;
    pend_kind_next = pend_kind;
    drop_next      = drop;
    rec0           = '0;
    rec1           = '0;
    nrec           = 2'd0;
    err            = 1'b0;
    err_code       = ST_OK;
    need_more      = 1'b0;
    go_reset       = 1'b0;

    if (drop) begin
      go_reset = last;
    end else begin
      if (phase == PH_HEADER) begin
        if (pos_inc < FIXED_HEADER) begin
          if (last) begin
            err      = 1'b1;
            err_code = ST_TRUNC;
          end else begin
            pos_next = pos_inc;
          end
        end else begin
          hdr_end_next = {doff, 2'b00};
          pos_next     = FIXED_HEADER;
          if (doff < MIN_OFFSET) begin
            err      = 1'b1;
            err_code = ST_OFFSET;
          end else if (last && doff > MIN_OFFSET) begin
            err      = 1'b1;
            err_code = ST_TRUNC;
          end else begin
            rec0                  = make_rec(REC_HEADER, 8'd0, 8'd0);
            rec0.src_port         = hdr_shift_next[159:144];
            rec0.dst_port         = hdr_shift_next[143:128];
            rec0.seq_number       = hdr_shift_next[127:96];
            rec0.ack_number       = hdr_shift_next[95:64];
            rec0.offset_and_flags = hdr_shift_next[63:48];
            rec0.window_size      = hdr_shift_next[47:32];
            rec0.checksum_word    = hdr_shift_next[31:16];
            rec0.urgent_pointer   = hdr_shift_next[15:0];
            nrec                  = 2'd1;
            phase_next = (doff == MIN_OFFSET) ? PH_PAYLOAD : PH_KIND;
          end
        end
      end else if (last && phase != PH_PAYLOAD && pos_inc < hdr_end) begin
        err      = 1'b1;
        err_code = ST_TRUNC;
      end else begin
        unique case (phase)
          PH_KIND: begin
            pos_next = pos_inc;
            if (b <= SINGLE_BYTE_MAX) begin
              rec0       = make_rec(REC_OPTION, b, 8'd0);
              nrec       = 2'd1;
              phase_next = (pos_inc >= hdr_end) ? PH_PAYLOAD : PH_KIND;
            end else begin
              pend_kind_next = b;
              phase_next     = PH_LEN;
              need_more      = 1'b1;
            end
          end
          PH_LEN: begin
            pos_next = pos_inc;
            if (b < KIND_LEN_BYTES) begin
              err      = 1'b1;
              err_code = ST_LENGTH;
            end else if (opt_end > {3'b000, hdr_end}) begin
              err      = 1'b1;
              err_code = ST_OVERRUN;
            end else begin
              rec0          = make_rec(REC_OPTION, pend_kind, dlen);
              nrec          = 2'd1;
              opt_left_next = dlen;
              if (dlen == 8'd0) begin
                phase_next = (pos_inc >= hdr_end) ? PH_PAYLOAD : PH_KIND;
              end else begin
                phase_next = PH_DATA;
                need_more  = 1'b1;
              end
            end
          end
          PH_DATA: begin
            pos_next      = pos_inc;
            rec0          = make_rec(REC_OPTDATA, b, 8'd0);
            nrec          = 2'd1;
            opt_left_next = opt_left - 8'd1;
            if (opt_left == 8'd1) begin
              phase_next = (pos_inc >= hdr_end) ? PH_PAYLOAD : PH_KIND;
            end else begin
              need_more = 1'b1;
            end
          end
          PH_PAYLOAD: begin
            rec0 = make_rec(REC_PAYLOAD, b, 8'd0);
            nrec = 2'd1;
          end
          default: begin
            go_reset = last;
          end
        endcase
      end

      // status record closes the run
      if (err || last) begin
        if (nrec == 2'd0) begin
          rec0 = make_rec(REC_STATUS, err ? err_code : (need_more ? ST_TRUNC : ST_OK),
                          8'd0);
        end else begin
          rec1 = make_rec(REC_STATUS, err ? err_code : (need_more ? ST_TRUNC : ST_OK),
                          8'd0);
        end
        nrec = nrec + 2'd1;
        if (last) begin
          go_reset = 1'b1;
        end else begin
          drop_next = 1'b1;
        end
      end

      if (nrec == 2'd1) begin
        rec0.last_of_run = 1'b1;
      end else if (nrec == 2'd2) begin
        rec1.last_of_run = 1'b1;
      end
    end

    if (go_reset) begin
      phase_next     = PH_HEADER;
      pos_next       = '0;
      hdr_end_next   = FIXED_HEADER;
      opt_left_next  = '0;
      pend_kind_next = '0;
      drop_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      hdr_end   <= FIXED_HEADER;
      opt_left  <= '0;
      pend_kind <= '0;
      drop      <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      hdr_end   <= hdr_end_next;
      opt_left  <= opt_left_next;
      pend_kind <= pend_kind_next;
      drop      <= drop_next;
    end
  end

  // header bytes only shift while the header is being collected
  always_ff @(posedge clk) begin
    if (accept && !drop && phase == PH_HEADER) begin
      hdr_shift <= hdr_shift_next;
    end
  end

  // record queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      rq_cnt <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + RQ_PTR_W'(nrec);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      rq_cnt <= rq_cnt + (accept ? RQ_CNT_W'(nrec) : RQ_CNT_W'(0))
                - (pop ? RQ_CNT_W'(1) : RQ_CNT_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nrec != 2'd0) begin
      rq[wr_ptr] <= rec0;
    end
    if (accept && nrec == 2'd2) begin
      rq[wr_ptr + RQ_PTR_W'(1)] <= rec1;
    end
  end

endmodule

/* tb/sv/tcp_header_option_parser_unit_test.sv */
module tcp_header_option_parser_unit_test;
  import tcpp_pkg::*;

  localparam int FLAW_NONE      = 0;
  localparam int FLAW_LENGTH    = 1;
  localparam int FLAW_OVERRUN   = 2;
  localparam int FLAW_EDGE_KIND = 3;

  localparam int BYTE_TARGET = 1550;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcpp_seg_if segment();
  tcpp_rec_if result();

  tcp_header_option_parser_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .segment (segment),
    .result  (result)
  );

  always #2 clk = ~clk;

  // parser state mirrored for prediction
  logic [2:0]   ps_phase;
  logic [5:0]   ps_pos;
  logic [159:0] ps_hdr;
  logic [5:0]   ps_hdr_end;
  logic [7:0]   ps_opt_left;
  logic [7:0]   ps_kind;
  logic         ps_dropping;

  rec_beat_t   expected_records[$];
  logic [7:0]  seg_bytes[$];
  int          failures = 0;
  int          parsed_bytes = 0;
  int          bytes_sent = 0;
  int          segments_sent = 0;
  int          record_counts[5] = '{0, 0, 0, 0, 0};
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;

  function automatic void clear_parser();
    ps_phase    = PH_HEADER;
    ps_pos      = '0;
    ps_hdr      = '0;
    ps_hdr_end  = FIXED_HEADER;
    ps_opt_left = '0;
    ps_kind     = '0;
    ps_dropping = 1'b0;
  endfunction

  function automatic rec_beat_t new_record(input logic [2:0] kind, input logic [7:0] value,
                                           input logic [7:0] dlen);
    rec_beat_t r;
    r = '0;
    r.record_type        = kind;
    r.item_value         = value;
    r.option_data_length = dlen;
    return r;
  endfunction

  function automatic void next_option_part();
    ps_phase = (ps_pos >= ps_hdr_end) ? PH_PAYLOAD : PH_KIND;
  endfunction

  // expected records for one accepted segment byte
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    rec_beat_t  out[2];
    int         n;
    logic       bad;
    logic [7:0] code;
    logic       need_more;
    int         dlen;
    n = 0;
    bad = 1'b0;
    code = ST_OK;
    need_more = 1'b0;
    if (ps_dropping) begin
      if (last) clear_parser();
      return;
    end
    parsed_bytes++;
    if (ps_phase == PH_HEADER) begin
      ps_hdr = {ps_hdr[151:0], b};
      if (int'(ps_pos) + 1 < int'(FIXED_HEADER)) begin
        if (last) begin
          bad = 1'b1;
          code = ST_TRUNC;
        end else begin
          ps_pos = ps_pos + 6'd1;
        end
      end else begin
        ps_hdr_end = {ps_hdr[63:60], 2'b00};
        ps_pos = FIXED_HEADER;
        if (ps_hdr[63:60] < MIN_OFFSET) begin
          bad = 1'b1;
          code = ST_OFFSET;
        end else if (last && ps_hdr_end > FIXED_HEADER) begin
          bad = 1'b1;
          code = ST_TRUNC;
        end else begin
          out[n] = new_record(REC_HEADER, 8'd0, 8'd0);
          out[n].src_port         = ps_hdr[159:144];
          out[n].dst_port         = ps_hdr[143:128];
          out[n].seq_number       = ps_hdr[127:96];
          out[n].ack_number       = ps_hdr[95:64];
          out[n].offset_and_flags = ps_hdr[63:48];
          out[n].window_size      = ps_hdr[47:32];
          out[n].checksum_word    = ps_hdr[31:16];
          out[n].urgent_pointer   = ps_hdr[15:0];
          n++;
          next_option_part();
        end
      end
    end else if (last && ps_phase != PH_PAYLOAD && int'(ps_pos) + 1 < int'(ps_hdr_end)) begin
      bad = 1'b1;
      code = ST_TRUNC;
    end else if (ps_phase == PH_KIND) begin
      ps_pos = ps_pos + 6'd1;
      if (b <= SINGLE_BYTE_MAX) begin
        out[n] = new_record(REC_OPTION, b, 8'd0);
        n++;
        next_option_part();
      end else begin
        ps_kind = b;
        ps_phase = PH_LEN;
        need_more = 1'b1;
      end
    end else if (ps_phase == PH_LEN) begin
      ps_pos = ps_pos + 6'd1;
      if (b < KIND_LEN_BYTES) begin
        bad = 1'b1;
        code = ST_LENGTH;
      end else begin
        dlen = int'(b) - int'(KIND_LEN_BYTES);
        if (int'(ps_pos) + dlen > int'(ps_hdr_end)) begin
          bad = 1'b1;
          code = ST_OVERRUN;
        end else begin
          out[n] = new_record(REC_OPTION, ps_kind, 8'(dlen));
          n++;
          ps_opt_left = 8'(dlen);
          if (dlen == 0) begin
            next_option_part();
          end else begin
            ps_phase = PH_DATA;
            need_more = 1'b1;
          end
        end
      end
    end else if (ps_phase == PH_DATA) begin
      ps_pos = ps_pos + 6'd1;
      out[n] = new_record(REC_OPTDATA, b, 8'd0);
      n++;
      ps_opt_left = ps_opt_left - 8'd1;
      if (ps_opt_left == 8'd0) next_option_part();
      else need_more = 1'b1;
    end else begin
      out[n] = new_record(REC_PAYLOAD, b, 8'd0);
      n++;
    end

    if (bad) begin
      out[n] = new_record(REC_STATUS, code, 8'd0);
      n++;
      if (last) clear_parser();
      else ps_dropping = 1'b1;
    end else if (last) begin
      out[n] = new_record(REC_STATUS, need_more ? ST_TRUNC : ST_OK, 8'd0);
      n++;
      clear_parser();
    end
    if (n > 0) out[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_records.insert(expected_records.size(), out[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : check_records
    rec_beat_t want;
    rec_beat_t got;
    if (!rst && result.valid && result.ready) begin
      got = result.payload;
      if (expected_records.size() == 0) begin
        $error("record beat with nothing expected: type %0d value 0x%0h",
               got.record_type, got.item_value);
        failures++;
      end else begin
        want = expected_records.pop_front();
        if (want.record_type < 3'd5) record_counts[want.record_type]++;
        check_field("record_type", want.record_type, got.record_type);
        check_field("src_port", want.src_port, got.src_port);
        check_field("dst_port", want.dst_port, got.dst_port);
        check_field("seq_number", want.seq_number, got.seq_number);
        check_field("ack_number", want.ack_number, got.ack_number);
        check_field("offset_and_flags", want.offset_and_flags, got.offset_and_flags);
        check_field("window_size", want.window_size, got.window_size);
        check_field("checksum_word", want.checksum_word, got.checksum_word);
        check_field("urgent_pointer", want.urgent_pointer, got.urgent_pointer);
        check_field("item_value", want.item_value, got.item_value);
        check_field("option_data_length", want.option_data_length, got.option_data_length);
        check_field("last_of_run", want.last_of_run, got.last_of_run);
      end
    end
  end

  // record side: random stalls, mostly short
  initial begin : record_sink
    int hold;
    hold = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        result.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("** tcp_header_option_parser_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int gap_len();
    int r;
    if (!src_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high between back-to-back beats
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      segment.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    segment.valid <= 1'b1;
    segment.payload <= {b, last};
    do @(posedge clk); while (!segment.ready);
    bytes_sent++;
    parse_byte(b, last);
  endtask

  task automatic send_segment();
    for (int i = 0; i < seg_bytes.size(); i++) send_byte(seg_bytes[i], i == seg_bytes.size() - 1);
    seg_bytes.delete();
    segments_sent++;
  endtask

  task automatic wait_drained();
    segment.valid <= 1'b0;
    do @(posedge clk); while (expected_records.size() != 0);
  endtask

  function automatic void append_byte(input logic [7:0] v);
    seg_bytes.insert(seg_bytes.size(), v);
  endfunction

  function automatic void push_random(input int count);
    repeat (count) append_byte(8'($urandom));
  endfunction

  function automatic void add_header(input logic [3:0] doff);
    push_random(12);
    append_byte({doff, 4'($urandom)});
    push_random(7);
  endfunction

  // fills the option area; a flaw, if any, ends the walk
  function automatic void add_options(input int room, input int flaw);
    int dlen;
    while (room > 0) begin
      if (flaw == FLAW_EDGE_KIND && room == 1) begin
        append_byte(8'($urandom_range(2, 255)));
        append_byte(8'($urandom_range(0, 255)));
        return;
      end
      if ((flaw == FLAW_LENGTH || flaw == FLAW_OVERRUN) &&
          (room <= 2 || $urandom_range(0, 2) == 0)) begin
        append_byte(8'($urandom_range(2, 255)));
        if (flaw == FLAW_LENGTH) append_byte(8'($urandom_range(0, 1)));
        else append_byte(8'($urandom_range(room + 1, 255)));
        return;
      end
      if (room < 2 || (flaw == FLAW_EDGE_KIND && room <= 3) || $urandom_range(0, 3) == 0) begin
        append_byte(8'($urandom_range(0, 1)));
        room--;
      end else begin
        dlen = ($urandom_range(0, 3) == 0) ? room - 2
                                           : $urandom_range(0, (room - 2 < 6) ? room - 2 : 6);
        append_byte(8'($urandom_range(2, 255)));
        append_byte(8'(dlen + 2));
        push_random(dlen);
        room -= dlen + 2;
      end
    end
  endfunction

  task automatic test_header_fields();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    // all ones, offset 5: header and ok status on the same beat
    repeat (12) append_byte(8'hFF);
    append_byte(8'h5F);
    repeat (7) append_byte(8'hFF);
    send_segment();
    // all zero apart from the offset, one zero payload byte
    repeat (12) append_byte(8'h00);
    append_byte(8'h50);
    repeat (8) append_byte(8'h00);
    send_segment();
    add_header(4'd5);
    append_byte(8'h00);
    append_byte(8'hFF);
    push_random(3);
    send_segment();
    wait_drained();
  endtask

  task automatic test_options();
    src_gaps = 1'b0;
    sink_stalls = 1'b1;
    // largest offset; last option's data ends right on the header end
    add_header(4'd15);
    append_byte(8'd1);
    append_byte(8'd0);
    append_byte(8'd1);
    append_byte(8'd2);
    append_byte(8'd2);
    append_byte(8'hFF);
    append_byte(8'd6);
    push_random(4);
    append_byte(8'd8);
    append_byte(8'd29);
    push_random(27);
    push_random(2);
    send_segment();
    // segment ends on the last option data byte
    add_header(4'd6);
    append_byte(8'd3);
    append_byte(8'd4);
    push_random(2);
    send_segment();
    wait_drained();
  endtask

  task automatic test_truncation();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    push_random(1);
    send_segment();
    add_header(4'd5);
    seg_bytes = seg_bytes[0:18];
    send_segment();
    // ends on the 20th byte while options are announced
    add_header(4'd7);
    send_segment();
    // ends inside option data
    add_header(4'd7);
    append_byte(8'd5);
    append_byte(8'd6);
    push_random(1);
    send_segment();
    // ends on a kind byte in the last header position
    add_header(4'd6);
    append_byte(8'd1);
    append_byte(8'd1);
    append_byte(8'd1);
    append_byte(8'd9);
    send_segment();
    // ends on a length byte with data still owed
    add_header(4'd6);
    append_byte(8'd2);
    append_byte(8'd4);
    send_segment();
    wait_drained();
  endtask

  task automatic test_bad_offset();
    src_gaps = 1'b1;
    sink_stalls = 1'b0;
    add_header(4'd0);
    send_segment();
    add_header(4'd4);
    push_random(5);
    send_segment();
    // clean segment right after the dropped bytes
    add_header(4'd5);
    push_random(2);
    send_segment();
    wait_drained();
  endtask

  task automatic test_bad_length();
    src_gaps = 1'b0;
    sink_stalls = 1'b1;
    add_header(4'd7);
    append_byte(8'd1);
    append_byte(8'd30);
    append_byte(8'd1);
    push_random(3);
    send_segment();
    // length byte read past the header end
    add_header(4'd6);
    repeat (3) append_byte(8'd0);
    append_byte(8'd7);
    append_byte(8'd0);
    push_random(2);
    send_segment();
    wait_drained();
  endtask

  task automatic test_overrun();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    add_header(4'd7);
    append_byte(8'd4);
    append_byte(8'd9);
    push_random(3);
    send_segment();
    add_header(4'd6);
    repeat (3) append_byte(8'd1);
    append_byte(8'd12);
    append_byte(8'd2);
    push_random(2);
    send_segment();
    add_header(4'd6);
    repeat (3) append_byte(8'd1);
    append_byte(8'd12);
    append_byte(8'd255);
    send_segment();
    wait_drained();
  endtask

  task automatic random_segment();
    int sel;
    int flaw;
    int doff;
    int npay;
    int keep;
    sel = $urandom_range(0, 99);
    flaw = FLAW_NONE;
    doff = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 15) : $urandom_range(5, 8);
    if (sel >= 97) begin
      push_random($urandom_range(1, 40));
      send_segment();
    end else begin
      if (sel >= 70 && sel < 76) begin
        doff = $urandom_range(0, 4);
      end else if (sel >= 76 && sel < 82) begin
        flaw = FLAW_LENGTH;
      end else if (sel >= 82 && sel < 88) begin
        flaw = FLAW_OVERRUN;
      end else if (sel >= 88 && sel < 92) begin
        flaw = FLAW_EDGE_KIND;
        if (doff < 6) doff = 6;
      end
      add_header(4'(doff));
      if (doff >= 5) add_options(doff * 4 - 20, flaw);
      npay = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      push_random(npay);
      if (sel >= 92) begin
        keep = $urandom_range(1, seg_bytes.size());
        seg_bytes = seg_bytes[0:keep - 1];
      end
      send_segment();
    end
  endtask

  // random segments until the total byte count reaches the target
  task automatic test_random_segments();
    int count;
    count = 0;
    while (bytes_sent < BYTE_TARGET) begin
      if (count % 8 == 0) begin
        src_gaps = $urandom_range(0, 2) != 0;
        sink_stalls = $urandom_range(0, 2) != 0;
      end
      random_segment();
      count++;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    segment.valid = 1'b0;
    segment.payload = '0;
    clear_parser();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_header_fields();
    test_options();
    test_truncation();
    test_bad_offset();
    test_bad_length();
    test_overrun();
    test_random_segments();
    repeat (40) @(posedge clk);
    $display("%0d segments, %0d bytes sent, %0d parsed outside error drops",
             segments_sent, bytes_sent, parsed_bytes);
    $display("records checked: %0d header, %0d option, %0d option data, %0d payload, %0d status",
             record_counts[0], record_counts[1], record_counts[2], record_counts[3],
             record_counts[4]);
    if (failures == 0) begin
      $display("** tcp_header_option_parser_unit: PASSED **");
    end else begin
      $display("** tcp_header_option_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
